// ----- rtl/core/tpsq_pkg.sv -----
// shared types, codes and constants for the position stability qualifier
package tpsq_pkg;

  // apb port geometry: four registers read and written as 32-bit words at byte addresses 0, 4, 8, 12
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  // field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 16;
  localparam int CONF_W = 8;
  localparam int RAD_W  = 12;
  localparam int CNT_W  = 8;

  // squared radius and squared distance widths
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int SQ_W   = 2 * POS_W;
  localparam int DIST_W = SQ_W + 1;

  // ring fill and run counters saturate at three
  localparam logic [1:0] RING_FULL = 2'd3;
  localparam logic [1:0] RUN_FULL  = 2'd3;

  // register reset values
  localparam logic [CONF_W-1:0] CONF_MIN_RST   = 8'd128;
  localparam logic [RAD_W-1:0]  RADIUS_RST     = 12'd32;
  localparam logic [RSQ_W-1:0]  RADIUS_SQ_RST  = 24'd1024;
  localparam logic [CNT_W-1:0]  WINDOW_RST     = 8'd32;
  localparam logic [CNT_W-1:0]  LOCK_MIN_RST   = 8'd30;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_DETECT = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_CONF_MIN = 2'd0,
    REG_RADIUS   = 2'd1,
    REG_WINDOW   = 2'd2,
    REG_LOCK_MIN = 2'd3
  } reg_idx_e;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CONF_W-1:0] confidence;
  } item_t;

  // result word
  typedef struct packed {
    logic position_stable;
    logic position_valid;
    logic lock_confirmed;
    logic window_closed;
  } result_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CONF_W-1:0] confidence_min;
    logic [RAD_W-1:0]  stability_radius;
    logic [RSQ_W-1:0]  radius_sq;
    logic [CNT_W-1:0]  window_updates;
    logic [CNT_W-1:0]  lock_min_stable;
  } cfg_t;

endpackage

// ----- rtl/core/tpsq_if.sv -----
// valid/ready stream interfaces for input and result words
interface tpsq_item_if;
  import tpsq_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpsq_result_if;
  import tpsq_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tpsq_regs.sv -----
// apb configuration registers with a precomputed squared radius
module tpsq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpsq_pkg::DATA_W-1:0]   pwdata,
  output logic [tpsq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tpsq_pkg::cfg_t                cfg
);
  import tpsq_pkg::*;

  logic              wr_en;
  reg_idx_e          idx;
  logic [RSQ_W-1:0]  rad_ext;
  logic [RSQ_W-1:0]  rad_sq_next;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  // squared radius for the distance compares, stored with each radius write
  assign rad_ext     = RSQ_W'(pwdata[RAD_W-1:0]);
  assign rad_sq_next = rad_ext * rad_ext;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confidence_min   <= CONF_MIN_RST;
      cfg.stability_radius <= RADIUS_RST;
      cfg.radius_sq        <= RADIUS_SQ_RST;
      cfg.window_updates   <= WINDOW_RST;
      cfg.lock_min_stable  <= LOCK_MIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CONF_MIN: cfg.confidence_min <= pwdata[CONF_W-1:0];
        REG_RADIUS: begin
          cfg.stability_radius <= pwdata[RAD_W-1:0];
          cfg.radius_sq        <= rad_sq_next;
        end
        REG_WINDOW:   cfg.window_updates  <= pwdata[CNT_W-1:0];
        REG_LOCK_MIN: cfg.lock_min_stable <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_CONF_MIN: prdata = DATA_W'(cfg.confidence_min);
      REG_RADIUS:   prdata = DATA_W'(cfg.stability_radius);
      REG_WINDOW:   prdata = DATA_W'(cfg.window_updates);
      REG_LOCK_MIN: prdata = DATA_W'(cfg.lock_min_stable);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/target_position_stability_qualifier_top.sv -----
// position stability qualifier: input register, single-pass update, result register
//
//   port     dir   handshake      word
//   items    in    valid/ready    cmd, pos_x, pos_y, confidence
//   results  out   valid/ready    position_stable, position_valid, lock_confirmed,
//                                 window_closed
//   apb      in    psel/penable   confidence_min, stability_radius, window_updates,
//                                 lock_min_stable
//
// one word per cycle sustained while results.ready holds; each word passes the input register
// and then the result register, from which its result is offered
// the pass holds one distance square pair, a 33-bit add and compare against r*r
// rst is synchronous and clears the ring, run count, window counters and lock flag
// a stalled result holds both stages; items.ready follows results.ready in that case
module target_position_stability_qualifier_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpsq_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpsq_pkg::DATA_W-1:0]   pwdata,
  output logic [tpsq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  tpsq_item_if.sink                     items,
  tpsq_result_if.source                 results
);
  import tpsq_pkg::*;

  cfg_t cfg;

  // input stage
  logic  in_valid;
  item_t in_word;
  logic  advance;

  // result stage
  logic    out_valid;
  result_t out_word;

  // qualifier state: newest centroid, the two latest squared moves, counters
  logic [POS_W-1:0]  last_x, last_y;
  logic [DIST_W-1:0] dist_new, dist_old;
  logic [1:0]        fill, stable_run;
  logic [CNT_W-1:0]  window_count, window_stable;
  logic              lock_flag;

  logic [POS_W-1:0]  last_x_next, last_y_next;
  logic [DIST_W-1:0] dist_new_next, dist_old_next;
  logic [1:0]        fill_next, stable_run_next;
  logic [CNT_W-1:0]  window_count_next, window_stable_next;
  logic              lock_flag_next;
  logic              closed;
  result_t           result_next;

  // datapath terms
  logic [POS_W-1:0]  dx, dy;
  logic [SQ_W-1:0]   dx_sq, dy_sq;
  logic [DIST_W-1:0] move_sq, rsq;
  logic              move_ok, stable_now, take_det;
  logic [CNT_W-1:0]  wc_inc, ws_inc;

  tpsq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: a word moves on when the result register is free or being drained
  assign advance       = in_valid && (!out_valid || results.ready);
  assign items.ready   = !in_valid || advance;
  assign results.valid = out_valid;
  assign results.data  = out_word;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_word <= items.data;
    end
  end

  // squared move from the newest centroid
  assign dx      = (in_word.pos_x >= last_x) ? in_word.pos_x - last_x : last_x - in_word.pos_x;
  assign dy      = (in_word.pos_y >= last_y) ? in_word.pos_y - last_y : last_y - in_word.pos_y;
  assign dx_sq   = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq   = SQ_W'(dy) * SQ_W'(dy);
  assign move_sq = DIST_W'(dx_sq) + DIST_W'(dy_sq);
  assign rsq     = DIST_W'(cfg.radius_sq);

  // an empty ring has no previous centroid, so the first detection counts as a good move
  assign move_ok    = (fill == 2'd0) || (move_sq <= rsq);
  assign stable_now = (fill == RING_FULL) && (stable_run == RUN_FULL) &&
                      (dist_new <= rsq) && (dist_old <= rsq);
  assign take_det   = (in_word.confidence >= cfg.confidence_min);
  assign wc_inc     = window_count + 1'b1;
  assign ws_inc     = stable_now ? window_stable + 1'b1 : window_stable;

  // next state and result for the word in the input register
  always_comb begin
    last_x_next        = last_x;
    last_y_next        = last_y;
    dist_new_next      = dist_new;
    dist_old_next      = dist_old;
    fill_next          = fill;
    stable_run_next    = stable_run;
    window_count_next  = window_count;
    window_stable_next = window_stable;
    lock_flag_next     = lock_flag;
    closed             = 1'b0;
    case (in_word.cmd)
      CMD_DETECT: begin
        if (take_det) begin
          last_x_next   = in_word.pos_x;
          last_y_next   = in_word.pos_y;
          dist_new_next = move_sq;
          dist_old_next = dist_new;
          fill_next     = (fill == RING_FULL) ? RING_FULL : fill + 1'b1;
          if (move_ok) begin
            stable_run_next = (stable_run == RUN_FULL) ? RUN_FULL : stable_run + 1'b1;
          end else begin
            stable_run_next = 2'd0;
          end
        end
      end
      CMD_LOCK: begin
        if (wc_inc >= cfg.window_updates) begin
          closed             = 1'b1;
          lock_flag_next     = (ws_inc >= cfg.lock_min_stable);
          window_count_next  = '0;
          window_stable_next = '0;
        end else begin
          window_count_next  = wc_inc;
          window_stable_next = ws_inc;
        end
      end
      CMD_CLEAR: begin
        fill_next          = 2'd0;
        stable_run_next    = 2'd0;
        window_count_next  = '0;
        window_stable_next = '0;
        lock_flag_next     = 1'b0;
      end
      default: ;
    endcase

    result_next.position_stable = (fill_next == RING_FULL) &&
                                  (stable_run_next == RUN_FULL) &&
                                  (dist_new_next <= rsq) && (dist_old_next <= rsq);
    result_next.position_valid  = (stable_run_next == RUN_FULL);
    result_next.lock_confirmed  = lock_flag_next;
    result_next.window_closed   = closed;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= 2'd0;
      stable_run    <= 2'd0;
      window_count  <= '0;
      window_stable <= '0;
      lock_flag     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        fill          <= fill_next;
        stable_run    <= stable_run_next;
        window_count  <= window_count_next;
        window_stable <= window_stable_next;
        lock_flag     <= lock_flag_next;
        out_valid     <= 1'b1;
      end else if (results.ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // centroid, move distances and result word
  always_ff @(posedge clk) begin
    if (advance) begin
      last_x   <= last_x_next;
      last_y   <= last_y_next;
      dist_new <= dist_new_next;
      dist_old <= dist_old_next;
      out_word <= result_next;
    end
  end

endmodule
